// ===== sv/heightmap_triangle_height_sampler_macros.svh =====
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLER_MACROS_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLER_MACROS_SVH

// same-cycle implication, off during reset
`define HMTS_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hmts check failed");

// next-cycle implication, off during reset
`define HMTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hmts check failed");

// next-cycle implication, checked during reset too
`define HMTS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("hmts check failed");

`endif

// ===== sv/hmts_pkg.sv =====
`default_nettype none

package hmts_pkg;

   localparam int MAP_SIDE_DEFAULT = 256;
   localparam int STORE_AW         = 16;
   localparam int STORE_DEPTH      = 1 << STORE_AW;
   localparam int FRAC_W           = 16;
   localparam int MOD_STEPS        = 16;
   localparam int OUT_W            = 27;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] REG_TILE_SIZE      = 2'd0;
   localparam logic [1:0] REG_VERTICAL_SCALE = 2'd1;
   localparam logic [1:0] REG_MIN_HEIGHT     = 2'd2;
   localparam logic [1:0] REG_MAX_HEIGHT     = 2'd3;

   localparam logic [15:0] TILE_SIZE_RESET      = 16'd8000;
   localparam logic [15:0] VERTICAL_SCALE_RESET = 16'd54400;
   localparam logic [15:0] MIN_HEIGHT_RESET     = 16'd0;
   localparam logic [15:0] MAX_HEIGHT_RESET     = 16'd65535;

   typedef struct packed {
      logic               opcode;
      logic [15:0]        load_index;
      logic [15:0]        load_height;
      logic signed [31:0] world_x;
      logic signed [31:0] world_z;
   } hmts_req_type;

   typedef struct packed {
      logic [OUT_W-1:0] height;
      logic             out_of_range;
   } hmts_rsp_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] load_index;
      logic [15:0] load_height;
   } hmts_tag_type;

   typedef struct packed {
      logic [15:0] h0;
      logic [15:0] h1;
      logic [15:0] h2;
      logic [15:0] h3;
   } hmts_corner_type;

   typedef struct packed {
      logic [15:0] vertical_scale;
      logic [15:0] min_height;
      logic [15:0] max_height;
   } hmts_window_type;

   // one restoring step: {quotient bit, next remainder}
   function automatic logic [16:0] hmts_div_step(input logic [15:0] rem,
                                                 input logic        din,
                                                 input logic [15:0] divisor);
      logic [16:0] cand;
      logic [16:0] diff;
      logic        ge;
      cand = {rem, din};
      diff = cand - {1'b0, divisor};
      ge   = (cand >= {1'b0, divisor});
      return {ge, (ge ? diff[15:0] : cand[15:0])};
   endfunction

   function automatic int hmts_loc_latency(input int map_side);
      return 3 + MOD_STEPS + $clog2(map_side) + FRAC_W;
   endfunction

endpackage

`default_nettype wire

// ===== sv/heightmap_triangle_height_sampler.sv =====
`default_nettype none

// channel  dir     handshake                          payload
// req      in      req_valid / req_stall              hmts_req_type
// rsp      out     rsp_valid / rsp_stall              hmts_rsp_type
// csr      in/out  csr_psel / csr_penable / pready    16-bit registers at 4 * index
//
// one request per cycle unless the output stalls; a query passes the one-bit-per-stage remainder
// and quotient chains of the two locate lanes, then the lookup and the interpolator
// a load writes all four heightmap copies once it reaches the lookup's second register stage
// reset clears the valid bits and loads the config defaults; heightmap is undefined until loaded
// the whole pipeline holds while a response sits stalled in the output register

module heightmap_triangle_height_sampler #(
   parameter int MAP_SIDE = hmts_pkg::MAP_SIDE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  hmts_pkg::hmts_req_type req_data,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hmts_pkg::hmts_rsp_type rsp_data,

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import hmts_pkg::*;

   localparam int CELL_W  = $clog2(MAP_SIDE);
   localparam int LOC_LAT = hmts_loc_latency(MAP_SIDE);

   logic              advance;
   logic              csr_write;
   logic [1:0]        csr_index;

   logic [15:0]       tile_size_ff;
   logic [15:0]       vertical_scale_ff;
   logic [15:0]       min_height_ff;
   logic [15:0]       max_height_ff;
   logic [15:0]       tile_eff;
   hmts_window_type   window;

   hmts_tag_type      tag_in;
   logic              dl_valid_ff [LOC_LAT];
   hmts_tag_type      dl_tag_ff   [LOC_LAT];

   logic [CELL_W-1:0] cell_x;
   logic [CELL_W-1:0] cell_z;
   logic [15:0]       frac_u;
   logic [15:0]       frac_v;

   logic              lk_valid;
   hmts_corner_type   lk_corner;
   logic [15:0]       lk_u;
   logic [15:0]       lk_v;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // config registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_ff      <= TILE_SIZE_RESET;
         vertical_scale_ff <= VERTICAL_SCALE_RESET;
         min_height_ff     <= MIN_HEIGHT_RESET;
         max_height_ff     <= MAX_HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_TILE_SIZE:      tile_size_ff      <= csr_pwdata[15:0];
            REG_VERTICAL_SCALE: vertical_scale_ff <= csr_pwdata[15:0];
            REG_MIN_HEIGHT:     min_height_ff     <= csr_pwdata[15:0];
            REG_MAX_HEIGHT:     max_height_ff     <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TILE_SIZE:      csr_prdata = {16'h0000, tile_size_ff};
         REG_VERTICAL_SCALE: csr_prdata = {16'h0000, vertical_scale_ff};
         REG_MIN_HEIGHT:     csr_prdata = {16'h0000, min_height_ff};
         REG_MAX_HEIGHT:     csr_prdata = {16'h0000, max_height_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // zero tile size acts as one
   assign tile_eff              = (tile_size_ff == '0) ? 16'd1 : tile_size_ff;
   assign window.vertical_scale = vertical_scale_ff;
   assign window.min_height     = min_height_ff;
   assign window.max_height     = max_height_ff;

   // request tag rides alongside the locate lanes
   assign tag_in.opcode      = req_data.opcode;
   assign tag_in.load_index  = req_data.load_index;
   assign tag_in.load_height = req_data.load_height;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LOC_LAT; i++) begin
            dl_valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         dl_valid_ff[0] <= req_valid;
         for (int i = 1; i < LOC_LAT; i++) begin
            dl_valid_ff[i] <= dl_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dl_tag_ff[0] <= tag_in;
         for (int i = 1; i < LOC_LAT; i++) begin
            dl_tag_ff[i] <= dl_tag_ff[i-1];
         end
      end
   end

   hmts_locate #(
      .MAP_SIDE (MAP_SIDE)
   ) u_locate_x (
      .clock (clock),
      .en    (advance),
      .world (req_data.world_x),
      .tile  (tile_eff),
      .grid  (cell_x),
      .frac  (frac_u)
   );

   hmts_locate #(
      .MAP_SIDE (MAP_SIDE)
   ) u_locate_z (
      .clock (clock),
      .en    (advance),
      .world (req_data.world_z),
      .tile  (tile_eff),
      .grid  (cell_z),
      .frac  (frac_v)
   );

   hmts_lookup #(
      .MAP_SIDE (MAP_SIDE)
   ) u_lookup (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .in_valid   (dl_valid_ff[LOC_LAT-1]),
      .in_tag     (dl_tag_ff[LOC_LAT-1]),
      .in_x       (cell_x),
      .in_z       (cell_z),
      .in_u       (frac_u),
      .in_v       (frac_v),
      .out_valid  (lk_valid),
      .out_corner (lk_corner),
      .out_u      (lk_u),
      .out_v      (lk_v)
   );

   hmts_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (lk_valid),
      .in_corner (lk_corner),
      .in_u      (lk_u),
      .in_v      (lk_v),
      .window    (window),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/hmts_locate.sv =====
`default_nettype none

module hmts_locate #(
   parameter int MAP_SIDE = hmts_pkg::MAP_SIDE_DEFAULT
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [31:0]          world,
   input  logic [15:0]                 tile,
   output logic [$clog2(MAP_SIDE)-1:0] grid,
   output logic [15:0]                 frac
);
   import hmts_pkg::*;

   localparam int CELL_W = $clog2(MAP_SIDE);
   localparam int QUO_W  = CELL_W + FRAC_W;
   localparam int SIDE_W = $clog2(MAP_SIDE + 1);
   localparam int PROD_W = 32 + SIDE_W;

   logic [33:0]       offset_in;
   logic              neg_in;
   logic [15:0]       mag_in;

   logic [15:0]       mod_rem_ff  [MOD_STEPS+1];
   logic [15:0]       mod_bits_ff [MOD_STEPS+1];
   logic              mod_neg_ff  [MOD_STEPS+1];
   logic [15:0]       mod_lo_ff   [MOD_STEPS+1];

   logic [15:0]       fixed_in;
   logic [31:0]       pos_ff;
   logic [PROD_W-1:0] prod_in;

   logic [15:0]       div_rem_ff  [QUO_W+1];
   logic [QUO_W-1:0]  div_bits_ff [QUO_W+1];

   // shift by half a tile, split into the upper 16 bits for the modulo and the low 16 bits
   assign offset_in = {{2{world[31]}}, world} - {3'b000, tile, 15'b0};
   assign neg_in    = offset_in[33];
   assign mag_in    = neg_in ? ~offset_in[31:16] : offset_in[31:16];

   always_ff @(posedge clock) begin
      if (en) begin
         mod_rem_ff[0]  <= '0;
         mod_bits_ff[0] <= mag_in;
         mod_neg_ff[0]  <= neg_in;
         mod_lo_ff[0]   <= offset_in[15:0];
      end
   end

   for (genvar i = 0; i < MOD_STEPS; i++) begin : g_mod
      logic [16:0] step_in;
      assign step_in = hmts_div_step(mod_rem_ff[i], mod_bits_ff[i][15], tile);
      always_ff @(posedge clock) begin
         if (en) begin
            mod_rem_ff[i+1]  <= step_in[15:0];
            mod_bits_ff[i+1] <= {mod_bits_ff[i][14:0], 1'b0};
            mod_neg_ff[i+1]  <= mod_neg_ff[i];
            mod_lo_ff[i+1]   <= mod_lo_ff[i];
         end
      end
   end

   // floor modulo for negative offsets
   assign fixed_in = mod_neg_ff[MOD_STEPS] ? (tile - 16'd1 - mod_rem_ff[MOD_STEPS])
                                           : mod_rem_ff[MOD_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff <= {fixed_in, mod_lo_ff[MOD_STEPS]};
      end
   end

   assign prod_in = PROD_W'(pos_ff) * PROD_W'(MAP_SIDE);

   always_ff @(posedge clock) begin
      if (en) begin
         div_rem_ff[0]  <= prod_in[QUO_W +: 16];
         div_bits_ff[0] <= prod_in[QUO_W-1:0];
      end
   end

   // quotient of scaled position by tile: cell in the upper bits, fraction below
   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      logic [16:0] step_in;
      assign step_in = hmts_div_step(div_rem_ff[i], div_bits_ff[i][QUO_W-1], tile);
      always_ff @(posedge clock) begin
         if (en) begin
            div_rem_ff[i+1]  <= step_in[15:0];
            div_bits_ff[i+1] <= {div_bits_ff[i][QUO_W-2:0], step_in[16]};
         end
      end
   end

   assign grid = div_bits_ff[QUO_W][QUO_W-1:FRAC_W];
   assign frac = div_bits_ff[QUO_W][FRAC_W-1:0];

endmodule

`default_nettype wire

// ===== sv/hmts_lookup.sv =====
`default_nettype none

module hmts_lookup #(
   parameter int MAP_SIDE = hmts_pkg::MAP_SIDE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  hmts_pkg::hmts_tag_type        in_tag,
   input  logic [$clog2(MAP_SIDE)-1:0]   in_x,
   input  logic [$clog2(MAP_SIDE)-1:0]   in_z,
   input  logic [15:0]                   in_u,
   input  logic [15:0]                   in_v,
   output logic                          out_valid,
   output hmts_pkg::hmts_corner_type     out_corner,
   output logic [15:0]                   out_u,
   output logic [15:0]                   out_v
);
   import hmts_pkg::*;

   localparam int CELL_W = $clog2(MAP_SIDE);

   logic [CELL_W-1:0]   x1_in;
   logic [STORE_AW-1:0] zb0_in;

   logic                l1_valid_ff;
   hmts_tag_type        l1_tag_ff;
   logic [CELL_W-1:0]   l1_x0_ff;
   logic [CELL_W-1:0]   l1_x1_ff;
   logic                l1_zwrap_ff;
   logic [STORE_AW-1:0] l1_zb0_ff;
   logic [15:0]         l1_u_ff;
   logic [15:0]         l1_v_ff;

   logic [STORE_AW-1:0] zb1_in;
   logic [STORE_AW-1:0] addr_in [4];

   logic                l2_valid_ff;
   hmts_tag_type        l2_tag_ff;
   logic [STORE_AW-1:0] l2_addr_ff [4];
   logic [15:0]         l2_u_ff;
   logic [15:0]         l2_v_ff;

   logic                store_we;
   logic [15:0]         rd_ff [4];
   logic                l3_valid_ff;
   logic [15:0]         l3_u_ff;
   logic [15:0]         l3_v_ff;

   assign x1_in  = (in_x == CELL_W'(MAP_SIDE - 1)) ? '0 : in_x + CELL_W'(1);
   assign zb0_in = STORE_AW'(in_z) * STORE_AW'(MAP_SIDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_valid_ff <= 1'b0;
      end else if (en) begin
         l1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l1_tag_ff   <= in_tag;
         l1_x0_ff    <= in_x;
         l1_x1_ff    <= x1_in;
         l1_zwrap_ff <= (in_z == CELL_W'(MAP_SIDE - 1));
         l1_zb0_ff   <= zb0_in;
         l1_u_ff     <= in_u;
         l1_v_ff     <= in_v;
      end
   end

   // row base of the next row wraps to zero at the map edge
   assign zb1_in     = l1_zwrap_ff ? '0 : l1_zb0_ff + STORE_AW'(MAP_SIDE);
   assign addr_in[0] = l1_zb0_ff + STORE_AW'(l1_x0_ff);
   assign addr_in[1] = l1_zb0_ff + STORE_AW'(l1_x1_ff);
   assign addr_in[2] = zb1_in + STORE_AW'(l1_x0_ff);
   assign addr_in[3] = zb1_in + STORE_AW'(l1_x1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         l2_valid_ff <= 1'b0;
      end else if (en) begin
         l2_valid_ff <= l1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l2_tag_ff <= l1_tag_ff;
         l2_u_ff   <= l1_u_ff;
         l2_v_ff   <= l1_v_ff;
         for (int k = 0; k < 4; k++) begin
            l2_addr_ff[k] <= addr_in[k];
         end
      end
   end

   assign store_we = en && l2_valid_ff && (l2_tag_ff.opcode == OP_LOAD);

   // one copy of the heightmap per corner, all written by the same load
   for (genvar k = 0; k < 4; k++) begin : g_copy
      logic [15:0] store_mem [STORE_DEPTH];
      always_ff @(posedge clock) begin
         if (store_we) begin
            store_mem[l2_tag_ff.load_index] <= l2_tag_ff.load_height;
         end
         if (en) begin
            rd_ff[k] <= store_mem[l2_addr_ff[k]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l3_valid_ff <= 1'b0;
      end else if (en) begin
         l3_valid_ff <= l2_valid_ff && (l2_tag_ff.opcode == OP_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l3_u_ff <= l2_u_ff;
         l3_v_ff <= l2_v_ff;
      end
   end

   assign out_valid     = l3_valid_ff;
   assign out_corner.h0 = rd_ff[0];
   assign out_corner.h1 = rd_ff[1];
   assign out_corner.h2 = rd_ff[2];
   assign out_corner.h3 = rd_ff[3];
   assign out_u         = l3_u_ff;
   assign out_v         = l3_v_ff;

endmodule

`default_nettype wire

// ===== sv/hmts_interp.sv =====
`default_nettype none

module hmts_interp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  hmts_pkg::hmts_corner_type  in_corner,
   input  logic [15:0]                in_u,
   input  logic [15:0]                in_v,
   input  hmts_pkg::hmts_window_type  window,
   output logic                       out_valid,
   output hmts_pkg::hmts_rsp_type     out_rsp
);
   import hmts_pkg::*;

   logic                lower_in;
   logic signed [16:0]  du_in;
   logic signed [16:0]  dv_in;

   logic                i1_valid_ff;
   logic signed [16:0]  i1_du_ff;
   logic signed [16:0]  i1_dv_ff;
   logic [15:0]         i1_h0_ff;
   logic [15:0]         i1_u_ff;
   logic [15:0]         i1_v_ff;

   logic signed [33:0]  pu_in;
   logic signed [33:0]  pv_in;
   logic                i2_valid_ff;
   logic signed [33:0]  i2_pu_ff;
   logic signed [33:0]  i2_pv_ff;
   logic [15:0]         i2_h0_ff;

   logic signed [34:0]  sum_in;
   logic                i3_valid_ff;
   logic signed [34:0]  i3_sum_ff;

   logic signed [34:0]  lo_bound;
   logic signed [34:0]  hi_bound;
   logic                flag_in;
   logic [31:0]         clamp_in;
   logic                i4_valid_ff;
   logic                i4_flag_ff;
   logic [31:0]         i4_clamp_ff;

   logic [47:0]         scaled_in;
   hmts_rsp_type        rsp_in;
   logic                rsp_valid_ff;
   hmts_rsp_type        rsp_ff;

   // lower triangle when u > v
   assign lower_in = (in_u > in_v);
   assign du_in    = lower_in ? ($signed({1'b0, in_corner.h1}) - $signed({1'b0, in_corner.h0}))
                              : ($signed({1'b0, in_corner.h3}) - $signed({1'b0, in_corner.h2}));
   assign dv_in    = lower_in ? ($signed({1'b0, in_corner.h3}) - $signed({1'b0, in_corner.h1}))
                              : ($signed({1'b0, in_corner.h2}) - $signed({1'b0, in_corner.h0}));

   assign pu_in  = i1_du_ff * $signed({1'b0, i1_u_ff});
   assign pv_in  = i1_dv_ff * $signed({1'b0, i1_v_ff});

   assign sum_in = $signed({3'b000, i2_h0_ff, 16'h0000})
                 + $signed({i2_pu_ff[33], i2_pu_ff})
                 + $signed({i2_pv_ff[33], i2_pv_ff});

   assign lo_bound = $signed({3'b000, window.min_height, 16'h0000});
   assign hi_bound = $signed({3'b000, window.max_height, 16'h0000});
   assign flag_in  = (i3_sum_ff < lo_bound) || (i3_sum_ff > hi_bound);
   assign clamp_in = i3_sum_ff[34] ? '0 : i3_sum_ff[31:0];

   assign scaled_in           = 48'(i4_clamp_ff) * 48'(window.vertical_scale);
   assign rsp_in.height       = i4_flag_ff ? '0 : scaled_in[47:21];
   assign rsp_in.out_of_range = i4_flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i1_valid_ff  <= 1'b0;
         i2_valid_ff  <= 1'b0;
         i3_valid_ff  <= 1'b0;
         i4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         i1_valid_ff  <= in_valid;
         i2_valid_ff  <= i1_valid_ff;
         i3_valid_ff  <= i2_valid_ff;
         i4_valid_ff  <= i3_valid_ff;
         rsp_valid_ff <= i4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         i1_du_ff    <= du_in;
         i1_dv_ff    <= dv_in;
         i1_h0_ff    <= in_corner.h0;
         i1_u_ff     <= in_u;
         i1_v_ff     <= in_v;
         i2_pu_ff    <= pu_in;
         i2_pv_ff    <= pv_in;
         i2_h0_ff    <= i1_h0_ff;
         i3_sum_ff   <= sum_in;
         i4_flag_ff  <= flag_in;
         i4_clamp_ff <= clamp_in;
         rsp_ff      <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/hmts_checker.sv =====
`default_nettype none

`include "heightmap_triangle_height_sampler_macros.svh"

module hmts_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input hmts_pkg::hmts_rsp_type rsp_data
);

   `HMTS_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   `HMTS_ASSERT_HOLDS(a_flag_zero, clock, reset, rsp_valid && rsp_data.out_of_range, rsp_data.height == '0)

   `HMTS_ASSERT_HOLDS(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   `HMTS_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind heightmap_triangle_height_sampler hmts_checker u_hmts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
   import hmts_pkg::*;

   localparam int MAP_SIDE         = MAP_SIDE_DEFAULT;
   localparam int PHASE_ITEMS      = 128;
   localparam int SETTLE_CYCLES    = 100;
   localparam logic [31:0] HALF_TILE_RESET = 32'd262144000;

   class hmts_scoreboard;
      logic [15:0]  heights [STORE_DEPTH];
      logic [15:0]  tile_size;
      logic [15:0]  vertical_scale;
      logic [15:0]  min_height;
      logic [15:0]  max_height;
      hmts_rsp_type expected_heights [$];
      int           mismatches;
      int           answers;
      int           loads;
      int           queries;
      int           flagged;

      function new();
         tile_size      = TILE_SIZE_RESET;
         vertical_scale = VERTICAL_SCALE_RESET;
         min_height     = MIN_HEIGHT_RESET;
         max_height     = MAX_HEIGHT_RESET;
         mismatches     = 0;
         answers        = 0;
         loads          = 0;
         queries        = 0;
         flagged        = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [15:0] value);
         case (index)
            REG_TILE_SIZE:      tile_size = value;
            REG_VERTICAL_SCALE: vertical_scale = value;
            REG_MIN_HEIGHT:     min_height = value;
            REG_MAX_HEIGHT:     max_height = value;
            default: ;
         endcase
      endfunction

      // world coordinate to map cell and q0.16 fraction
      function void locate(input logic [31:0] world, output int grid, output int frac);
         longint t;
         longint d;
         longint p;
         longint r;
         longint s;
         longint c;
         t = (tile_size == 16'd0) ? 64'sd1 : longint'(tile_size);
         d = t * 65536;
         p = longint'(signed'(world)) - t * 32768;
         r = p % d;
         if (r < 0) begin
            r = r + d;
         end
         s = r * MAP_SIDE;
         c = s / d;
         grid = int'(c);
         frac = int'((s - c * d) / t);
      endfunction

      function int entry(int x, int z);
         return (z * MAP_SIDE + x) & (STORE_DEPTH - 1);
      endfunction

      function hmts_rsp_type sample_height(hmts_req_type item);
         int           x0;
         int           z0;
         int           x1;
         int           z1;
         int           u;
         int           v;
         longint       h0;
         longint       h1;
         longint       h2;
         longint       h3;
         longint       du;
         longint       dv;
         longint       acc;
         longint       scaled;
         hmts_rsp_type res;
         locate(item.world_x, x0, u);
         locate(item.world_z, z0, v);
         x1 = (x0 + 1) % MAP_SIDE;
         z1 = (z0 + 1) % MAP_SIDE;
         h0 = longint'(heights[entry(x0, z0)]);
         h1 = longint'(heights[entry(x1, z0)]);
         h2 = longint'(heights[entry(x0, z1)]);
         h3 = longint'(heights[entry(x1, z1)]);
         if (u > v) begin
            du = h1 - h0;
            dv = h3 - h1;
         end else begin
            du = h3 - h2;
            dv = h2 - h0;
         end
         acc = h0 * 65536 + du * u + dv * v;
         res = '0;
         if (acc < longint'(min_height) * 65536 || acc > longint'(max_height) * 65536) begin
            res.out_of_range = 1'b1;
         end else begin
            if (acc < 0) begin
               acc = 0;
            end
            scaled = (acc * longint'(vertical_scale)) >> 21;
            res.height = scaled[OUT_W-1:0];
         end
         return res;
      endfunction

      function void note_request(hmts_req_type item);
         hmts_rsp_type res;
         if (item.opcode == OP_LOAD) begin
            heights[item.load_index] = item.load_height;
            loads++;
         end else begin
            res = sample_height(item);
            expected_heights = {expected_heights, res};
            queries++;
            if (res.out_of_range) begin
               flagged++;
            end
         end
      endfunction

      function void check_result(hmts_rsp_type got);
         hmts_rsp_type want;
         answers++;
         if (expected_heights.size() == 0) begin
            if (mismatches < 20) begin
               $display("%0t: answer with no query waiting, height %0d out_of_range %0b",
                        $time, got.height, got.out_of_range);
            end
            mismatches++;
            return;
         end
         want = expected_heights.pop_front();
         if (got.height !== want.height) begin
            if (mismatches < 20) begin
               $display("%0t: height expected %0d actual %0d", $time, want.height, got.height);
            end
            mismatches++;
         end
         if (got.out_of_range !== want.out_of_range) begin
            if (mismatches < 20) begin
               $display("%0t: out_of_range expected %0b actual %0b",
                        $time, want.out_of_range, got.out_of_range);
            end
            mismatches++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   hmts_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   hmts_rsp_type rsp_data;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   hmts_scoreboard sb;
   bit             loaded [STORE_DEPTH];
   int             requests_taken = 0;
   int             items_sent = 0;
   int             stall_left = 0;
   int             settings_run = 1;
   bit             calm = 1'b0;

   heightmap_triangle_height_sampler #(.MAP_SIDE(MAP_SIDE)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int pick_pause();
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 15);
      end
      return $urandom_range(30, 60);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_pause();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_data);
            requests_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_data);
         end
      end
   end

   task automatic send_request(hmts_req_type item);
      int pause;
      int seen;
      pause = pick_pause();
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      seen = requests_taken;
      do @(negedge clock); while (requests_taken == seen);
      items_sent++;
   endtask

   function automatic logic [15:0] random_height();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 16'h0000;
      end else if (r == 1) begin
         return 16'hFFFF;
      end
      return 16'($urandom);
   endfunction

   task automatic send_load(logic [15:0] index, logic [15:0] value);
      hmts_req_type item;
      item.opcode      = OP_LOAD;
      item.load_index  = index;
      item.load_height = value;
      item.world_x     = $urandom;
      item.world_z     = $urandom;
      loaded[index]    = 1'b1;
      send_request(item);
   endtask

   // corners that were never loaded get a load first
   task automatic send_query(logic [31:0] wx, logic [31:0] wz);
      int           x0;
      int           z0;
      int           u;
      int           v;
      int           corner [4];
      hmts_req_type item;
      sb.locate(wx, x0, u);
      sb.locate(wz, z0, v);
      corner[0] = sb.entry(x0, z0);
      corner[1] = sb.entry((x0 + 1) % MAP_SIDE, z0);
      corner[2] = sb.entry(x0, (z0 + 1) % MAP_SIDE);
      corner[3] = sb.entry((x0 + 1) % MAP_SIDE, (z0 + 1) % MAP_SIDE);
      foreach (corner[i]) begin
         if (!loaded[corner[i]]) begin
            send_load(16'(corner[i]), random_height());
         end
      end
      item.opcode      = OP_QUERY;
      item.load_index  = 16'($urandom);
      item.load_height = 16'($urandom);
      item.world_x     = wx;
      item.world_z     = wz;
      send_request(item);
   endtask

   function automatic longint tile_units();
      return (sb.tile_size == 16'd0) ? 64'sd1 : longint'(sb.tile_size);
   endfunction

   function automatic int cluster_cell();
      int c;
      c = $urandom_range(0, 11);
      return (c < 6) ? c : c + 244;
   endfunction

   function automatic logic [31:0] near_cell(int c);
      longint t;
      longint w;
      t = tile_units();
      w = t * 32768 + longint'(c) * t * 256 + longint'($urandom_range(0, 32'(t * 256 - 1)))
          + longint'(int'($urandom_range(0, 4)) - 2) * t * 65536;
      return w[31:0];
   endfunction

   function automatic logic [31:0] tile_edge();
      longint t;
      longint w;
      t = tile_units();
      w = t * 32768 + longint'(int'($urandom_range(0, 4)) - 2) * t * 65536
          + longint'(int'($urandom_range(0, 6)) - 3);
      return w[31:0];
   endfunction

   task automatic write_register(logic [1:0] index, logic [15:0] value);
      logic [31:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {16'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      sb.set_register(index, value);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[15:0] !== value) begin
         $display("%0t: register %0d read expected %0d actual %0d",
                  $time, index, value, readback[15:0]);
         sb.mismatches++;
      end
   endtask

   task automatic configure(logic [15:0] tile, logic [15:0] scale,
                            logic [15:0] lowest, logic [15:0] highest);
      write_register(REG_TILE_SIZE, tile);
      write_register(REG_VERTICAL_SCALE, scale);
      write_register(REG_MIN_HEIGHT, lowest);
      write_register(REG_MAX_HEIGHT, highest);
      settings_run++;
   endtask

   // loads give no answer, so wait out the pipeline too
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_heights.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_directed();
      send_load(16'h0000, 16'h0000);
      send_load(16'hFFFF, 16'hFFFF);
      send_load(16'h5555, 16'hAAAA);
      send_load(16'hAAAA, 16'h5555);
      send_query(HALF_TILE_RESET, HALF_TILE_RESET);
      // last cell, neighbors wrap to the first row and column
      send_query(HALF_TILE_RESET - 32'd1, HALF_TILE_RESET - 32'd1);
      send_query(32'h7FFFFFFF, 32'h80000000);
      send_query(32'h80000000, 32'h7FFFFFFF);
      send_query(HALF_TILE_RESET + 32'd1500000, HALF_TILE_RESET + 32'd10);
      send_query(HALF_TILE_RESET + 32'd10, HALF_TILE_RESET + 32'd1500000);
      send_query(32'd0, 32'hFFFFFFFF);
   endtask

   task automatic run_random(int budget);
      int stop;
      int pick;
      stop = items_sent + budget;
      while (items_sent < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            send_load(16'($urandom), random_height());
         end else if (pick < 55) begin
            send_query(near_cell(cluster_cell()), near_cell(cluster_cell()));
         end else if (pick < 80) begin
            send_query($urandom, $urandom);
         end else if (pick < 90) begin
            send_query(tile_edge(), near_cell(cluster_cell()));
         end else begin
            send_query(tile_edge(), tile_edge());
         end
      end
   endtask

   initial begin
      logic [15:0] lowest;
      sb = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(PHASE_ITEMS);
      settle();

      configure(16'd1, 16'd65535, 16'd0, 16'd65535);
      run_random(PHASE_ITEMS);
      settle();

      configure(16'd65535, 16'd0, 16'd0, 16'd65535);
      calm = 1'b1;
      run_random(PHASE_ITEMS);
      calm = 1'b0;
      settle();

      // zero tile size behaves as one
      configure(16'd0, 16'd32, 16'd16384, 16'd49152);
      run_random(PHASE_ITEMS);
      settle();

      // inverted window flags everything
      configure(16'd8000, 16'd54400, 16'd40000, 16'd20000);
      run_random(PHASE_ITEMS);
      settle();

      configure(16'd300, 16'd54400, 16'd32768, 16'd32768);
      run_random(PHASE_ITEMS);
      settle();

      repeat (3) begin
         lowest = 16'($urandom_range(0, 40000));
         configure(16'($urandom_range(1, 65535)), 16'($urandom), lowest,
                   16'($urandom_range(lowest, 65535)));
         run_random(PHASE_ITEMS);
         settle();
      end

      configure(TILE_SIZE_RESET, VERTICAL_SCALE_RESET, MIN_HEIGHT_RESET, MAX_HEIGHT_RESET);
      run_random(PHASE_ITEMS);
      settle();

      $display("covered %0d map loads and %0d height queries under %0d register settings",
               sb.loads, sb.queries, settings_run);
      $display("%0d answers checked, %0d of them outside the height window",
               sb.answers, sb.flagged);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
